// ----- rtl/spd_pkg.sv -----
// spd_pkg: shared types and constants of the serial packet deframer
// no dependencies; used by spd_frame, spd_link and serial_packet_deframer_unit
`default_nettype none

package spd_pkg;

    // framing bytes
    localparam logic [7:0] START_A      = 8'h7E;
    localparam logic [7:0] START_B_BASE = 8'h7C;
    localparam logic [7:0] END_BYTE     = 8'h7F;

    // tick counters saturate here
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // item kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_VERSION      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RESET_ENABLE = 3'd4;

    // configuration reset values
    localparam logic [15:0] CONNECT_TIMEOUT_RST = 16'd500;
    localparam logic [15:0] IDLE_TIMEOUT_RST    = 16'd1000;

    typedef enum logic [4:0] {
        ST_WAIT_A  = 5'b00001,
        ST_WAIT_B  = 5'b00010,
        ST_TYPE    = 5'b00100,
        ST_LENGTH  = 5'b01000,
        ST_PAYLOAD = 5'b10000
    } t_parse_state;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic        idle_reset_enable;
        logic [15:0] idle_timeout_ticks;
        logic [15:0] connect_timeout_ticks;
    } t_link_cfg;

    // what the parser reports for one item
    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic       frame_done;
        logic       frame_dropped;
    } t_frame_evt;

    // what the link supervisor reports for one item
    typedef struct packed {
        logic connected;
        logic idle_fire;
    } t_link_evt;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] packet_type;
        logic [7:0] declared_length;
        logic       frame_done;
        logic       frame_dropped;
        logic       link_connected;
        logic       parser_reset;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/serial_packet_deframer_unit.sv -----
// serial_packet_deframer_unit: top level with input register, result register
// and configuration registers; depends on spd_pkg, spd_frame, spd_link
`default_nettype none

// Deframes a received UART byte stream and supervises the link. Each input
// transaction is a received byte (action 0) or one time tick (action 1), and
// each gives exactly one result transaction. A frame is 0x7E, the second start
// byte (0x7C + link_version, mod 256), a type byte, a length byte (kept, not
// checked), payload and 0x7F; there is no escaping. Payload bytes stream out
// as they arrive, a frame longer than MAX_PAYLOAD is dropped. A good frame
// sets link_connected; it clears when more than connect_timeout_ticks ticks
// pass without one. With idle_reset_enable set, the parser is reset once
// after more than idle_timeout_ticks ticks without any byte. Throughput is one
// transaction per clock while the output is not stalled: a transaction sits in
// the input register, its whole parse and counter update is combinational and
// lands in the result register, from which the result is offered; the move
// from the input register to the result register waits while the output is
// stalled. The input register and the result register each hold one
// transaction: while a result waits, the input takes one more transaction and
// then stalls until the waiting result is taken.
// Configuration registers are written through the plain write port and must
// only change while no transaction is in flight.

module serial_packet_deframer_unit #(
    parameter int MAX_PAYLOAD = 255
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [spd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [spd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_action,
    input  wire logic [7:0]                       i_rx_byte,
    // output channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_payload_valid,
    output logic [7:0]                            o_payload_byte,
    output logic [7:0]                            o_packet_type,
    output logic [7:0]                            o_declared_length,
    output logic                                  o_frame_done,
    output logic                                  o_frame_dropped,
    output logic                                  o_link_connected,
    output logic                                  o_parser_reset
);

    // configuration registers
    logic        r_block_enable;
    logic [7:0]  r_link_version;
    logic [15:0] r_connect_timeout;
    logic [15:0] r_idle_timeout;
    logic        r_idle_reset_enable;

    // input register
    logic            r_in_vld;
    spd_pkg::t_item  r_item;

    // result register
    logic             r_out_vld;
    spd_pkg::t_result r_out, n_out;

    logic                advance;   // transaction moves from input to result register
    logic                proc;      // state update happens for this transaction
    spd_pkg::t_link_cfg  link_cfg;
    spd_pkg::t_frame_evt frame_evt;
    spd_pkg::t_link_evt  link_evt;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign proc       = advance && r_block_enable;
    assign o_in_ready = !r_in_vld || advance;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_enable      <= 1'b1;
            r_link_version      <= '0;
            r_connect_timeout   <= spd_pkg::CONNECT_TIMEOUT_RST;
            r_idle_timeout      <= spd_pkg::IDLE_TIMEOUT_RST;
            r_idle_reset_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spd_pkg::CFG_BLOCK_ENABLE:      r_block_enable      <= i_cfg_wdata[0];
                spd_pkg::CFG_LINK_VERSION:      r_link_version      <= i_cfg_wdata[7:0];
                spd_pkg::CFG_CONNECT_TIMEOUT:   r_connect_timeout   <= i_cfg_wdata[15:0];
                spd_pkg::CFG_IDLE_TIMEOUT:      r_idle_timeout      <= i_cfg_wdata[15:0];
                spd_pkg::CFG_IDLE_RESET_ENABLE: r_idle_reset_enable <= i_cfg_wdata[0];
                default: begin
                    // writes beyond the register list are ignored
                end
            endcase
        end
    end

    assign link_cfg.idle_reset_enable     = r_idle_reset_enable;
    assign link_cfg.idle_timeout_ticks    = r_idle_timeout;
    assign link_cfg.connect_timeout_ticks = r_connect_timeout;

    // input register, refilled as soon as its transaction moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.action  <= i_action;
            r_item.rx_byte <= i_rx_byte;
        end
    end

    // frame parser
    spd_frame #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_proc         (proc),
        .i_item         (r_item),
        .i_link_version (r_link_version),
        .i_idle_fire    (link_evt.idle_fire),
        .o_evt          (frame_evt)
    );

    // link supervisor
    spd_link u_link (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_proc       (proc),
        .i_action     (r_item.action),
        .i_frame_done (frame_evt.frame_done),
        .i_cfg        (link_cfg),
        .o_evt        (link_evt)
    );

    // result assembly, all zero while the block is disabled
    always_comb begin
        n_out = '0;
        if (r_block_enable) begin
            n_out.payload_valid   = frame_evt.payload_valid;
            n_out.payload_byte    = frame_evt.payload_byte;
            n_out.packet_type     = frame_evt.frame_type;
            n_out.declared_length = frame_evt.frame_length;
            n_out.frame_done      = frame_evt.frame_done;
            n_out.frame_dropped   = frame_evt.frame_dropped;
            n_out.link_connected  = link_evt.connected;
            n_out.parser_reset    = link_evt.idle_fire;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_payload_valid   = r_out.payload_valid;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_packet_type     = r_out.packet_type;
    assign o_declared_length = r_out.declared_length;
    assign o_frame_done      = r_out.frame_done;
    assign o_frame_dropped   = r_out.frame_dropped;
    assign o_link_connected  = r_out.link_connected;
    assign o_parser_reset    = r_out.parser_reset;

    // a completed frame always leaves the link connected
    a_done_connects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> o_link_connected)
        else $error("frame done without link connected");

    // a result carries at most one of payload, frame end, drop
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_payload_valid, o_frame_done, o_frame_dropped}))
        else $error("conflicting frame events in one result");

    // the end byte is never passed on as payload
    a_no_end_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_payload_valid) |-> (o_payload_byte != spd_pkg::END_BYTE))
        else $error("end byte streamed as payload");

    // a parser reset only happens on a tick, never with byte events
    a_reset_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_parser_reset) |-> (!o_payload_valid && !o_frame_done))
        else $error("parser reset together with byte event");

    // results appear only after a transaction was held in the input register
    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid)) |-> $past(r_in_vld))
        else $error("result without input transaction");

endmodule

`default_nettype wire

// ----- rtl/spd_frame.sv -----
// spd_frame: frame parser state machine, header registers and payload counter
// depends on spd_pkg
`default_nettype none

module spd_frame #(
    parameter int MAX_PAYLOAD = 255
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_proc,
    input  wire spd_pkg::t_item     i_item,
    input  wire logic [7:0]         i_link_version,
    input  wire logic               i_idle_fire,
    output spd_pkg::t_frame_evt     o_evt
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PAYLOAD);

    spd_pkg::t_parse_state r_state, n_state;
    logic [7:0]            r_type, n_type;
    logic [7:0]            r_length, n_length;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [7:0]            start_b;

    assign start_b = spd_pkg::START_B_BASE + i_link_version;

    always_comb begin
        n_state  = r_state;
        n_type   = r_type;
        n_length = r_length;
        n_count  = r_count;
        o_evt    = '0;
        if (i_item.action == spd_pkg::ACT_BYTE) begin
            case (r_state)
                spd_pkg::ST_WAIT_A: begin
                    if (i_item.rx_byte == spd_pkg::START_A) begin
                        n_state = spd_pkg::ST_WAIT_B;
                    end
                end
                spd_pkg::ST_WAIT_B: begin
                    n_state = (i_item.rx_byte == start_b) ? spd_pkg::ST_TYPE
                                                          : spd_pkg::ST_WAIT_A;
                end
                spd_pkg::ST_TYPE: begin
                    n_type  = i_item.rx_byte;
                    n_state = spd_pkg::ST_LENGTH;
                end
                spd_pkg::ST_LENGTH: begin
                    n_length = i_item.rx_byte;
                    n_count  = '0;
                    n_state  = spd_pkg::ST_PAYLOAD;
                end
                spd_pkg::ST_PAYLOAD: begin
                    if (i_item.rx_byte == spd_pkg::END_BYTE) begin
                        n_state          = spd_pkg::ST_WAIT_A;
                        o_evt.frame_done = 1'b1;
                    end else if (r_count < CNT_LIMIT) begin
                        n_count             = r_count + 1'b1;
                        o_evt.payload_valid = 1'b1;
                        o_evt.payload_byte  = i_item.rx_byte;
                    end else begin
                        n_state             = spd_pkg::ST_WAIT_A;
                        o_evt.frame_dropped = 1'b1;
                    end
                end
                default: begin
                    n_state = spd_pkg::ST_WAIT_A;
                end
            endcase
        end else if (i_idle_fire) begin
            o_evt.frame_dropped = (r_state != spd_pkg::ST_WAIT_A);
            n_state = spd_pkg::ST_WAIT_A;
            n_count = '0;
        end
        o_evt.frame_type   = n_type;
        o_evt.frame_length = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= spd_pkg::ST_WAIT_A;
            r_type   <= '0;
            r_length <= '0;
            r_count  <= '0;
        end else if (i_proc) begin
            r_state  <= n_state;
            r_type   <= n_type;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/spd_link.sv -----
// spd_link: link supervision, tick counters, connected flag and idle reset
// depends on spd_pkg
`default_nettype none

module spd_link (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_proc,
    input  wire logic               i_action,
    input  wire logic               i_frame_done,
    input  wire spd_pkg::t_link_cfg i_cfg,
    output spd_pkg::t_link_evt      o_evt
);

    logic [15:0] r_tsf, n_tsf;
    logic [15:0] r_tsb, n_tsb;
    logic        r_connected, n_connected;
    logic        r_idle_done, n_idle_done;
    logic [15:0] tsf_inc, tsb_inc;
    logic        idle_fire;

    assign tsf_inc = (r_tsf == spd_pkg::CNT_MAX) ? r_tsf : r_tsf + 16'd1;
    assign tsb_inc = (r_tsb == spd_pkg::CNT_MAX) ? r_tsb : r_tsb + 16'd1;

    assign idle_fire = (i_action == spd_pkg::ACT_TICK) && i_cfg.idle_reset_enable
                       && !r_idle_done && (tsb_inc > i_cfg.idle_timeout_ticks);

    always_comb begin
        n_tsf       = r_tsf;
        n_tsb       = r_tsb;
        n_connected = r_connected;
        n_idle_done = r_idle_done;
        if (i_action == spd_pkg::ACT_BYTE) begin
            n_tsb       = '0;
            n_idle_done = 1'b0;
            if (i_frame_done) begin
                n_connected = 1'b1;
                n_tsf       = '0;
            end
        end else begin
            n_tsf = tsf_inc;
            n_tsb = tsb_inc;
            if (r_connected && (tsf_inc > i_cfg.connect_timeout_ticks)) begin
                n_connected = 1'b0;
            end
            if (idle_fire) begin
                n_idle_done = 1'b1;
            end
        end
        o_evt.connected = n_connected;
        o_evt.idle_fire = idle_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsf       <= '0;
            r_tsb       <= '0;
            r_connected <= 1'b0;
            r_idle_done <= 1'b0;
        end else if (i_proc) begin
            r_tsf       <= n_tsf;
            r_tsb       <= n_tsb;
            r_connected <= n_connected;
            r_idle_done <= n_idle_done;
        end
    end

endmodule

`default_nettype wire
